### sv/assert_macros.svh
// assertion macros for the rtl, included by sorted_table_insert_search
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, off while reset is asserted
`define STIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define STIS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/stis_pkg.sv
// ----------------------------------------------------------------------------
// stis_pkg
// shared constants, request codes and memory port types of the sorted table
// ----------------------------------------------------------------------------
package stis_pkg;

  localparam int DEPTH   = 64;
  localparam int VALUE_W = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  // one read port and one write port per cycle
  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    value_t wr_data;
  } mem_req_t;

endpackage

### sv/stis_store.sv
// ----------------------------------------------------------------------------
// stis_store
// value store of the sorted table: one write port, one registered read port
// ----------------------------------------------------------------------------
module stis_store import stis_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output value_t   rd_data
);

  value_t mem [DEPTH];
  value_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/sorted_table_insert_search.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_search
// sorted store of signed values with ordered insert and binary search
// ----------------------------------------------------------------------------
// usage:
//   an item is taken at a rising edge with start high and busy low; it is a
//   request code (clear, append, search; code 3 does nothing) and a value.
//   every item gives exactly one result, shown for one cycle with out_valid.
//   clear and unused codes: result one cycle after the item, busy stays low.
//   append: walks down from the top entry, one entry moved per cycle through
//   the store's separate read and write ports until the key's place is found;
//   an empty or full store answers without going busy.
//   search: binary search, each probe a read state and then a compare
//   state, since the store's read port is registered.
//   out_entry_total is the count after the request; out_status flags an
//   append dropped on a full store.
//   reset empties the store (count to zero); values need no clearing.
//   the receiver cannot stall: results are registered and shown once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_table_insert_search import stis_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic              out_valid,
  output logic              out_found,
  output logic [ADDR_W-1:0] out_position,
  output logic [CNT_W-1:0]  out_rank,
  output logic [CNT_W-1:0]  out_entry_total,
  output logic              out_status
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_INS      = 5'b00010,
    ST_INS_PUT  = 5'b00100,
    ST_SRCH_RD  = 5'b01000,
    ST_SRCH_CMP = 5'b10000
  } state_t;

  state_t   state_r, state_nxt;
  cnt_t     cnt_r, cnt_nxt;
  addr_t    j_r, j_nxt;
  cnt_t     lo_r, lo_nxt;
  cnt_t     hi1_r, hi1_nxt;
  addr_t    mid_r, mid_nxt;
  value_t   key_r, key_nxt;
  mem_req_t mem_req;
  value_t   rd_data;

  logic     fin;
  logic     fin_found;
  addr_t    fin_pos;
  cnt_t     fin_rank;
  logic     fin_status;

  logic [CNT_W:0] mid_sum;

  logic     out_valid_r;
  logic     out_found_r;
  addr_t    out_position_r;
  cnt_t     out_rank_r;
  cnt_t     out_entry_total_r;
  logic     out_status_r;

  stis_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // floor midpoint of lo .. hi1-1
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi1_r} - (CNT_W+1)'(1);

  // request sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    j_nxt      = j_r;
    lo_nxt     = lo_r;
    hi1_nxt    = hi1_r;
    mid_nxt    = mid_r;
    key_nxt    = key_r;
    mem_req    = '0;
    fin        = 1'b0;
    fin_found  = 1'b0;
    fin_pos    = '0;
    fin_rank   = '0;
    fin_status = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt = in_value;
          case (in_req_type)
            REQ_CLEAR: begin
              cnt_nxt = '0;
              fin     = 1'b1;
            end
            REQ_APPEND: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end else if (cnt_r == '0) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = in_value;
                cnt_nxt         = CNT_W'(1);
                fin             = 1'b1;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cnt_r[ADDR_W-1:0] - ADDR_W'(1);
                j_nxt           = cnt_r[ADDR_W-1:0];
                state_nxt       = ST_INS;
              end
            end
            REQ_SEARCH: begin
              if (cnt_r == '0) begin
                fin = 1'b1;
              end else begin
                lo_nxt    = '0;
                hi1_nxt   = cnt_r;
                state_nxt = ST_SRCH_RD;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_INS: begin
        // rd_data holds the entry just below the hole at j
        if (key_r < rd_data) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = j_r;
          mem_req.wr_data = rd_data;
          j_nxt           = j_r - ADDR_W'(1);
          if (j_r != ADDR_W'(1)) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = j_r - ADDR_W'(2);
          end else begin
            state_nxt = ST_INS_PUT;
          end
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = j_r;
          mem_req.wr_data = key_r;
          cnt_nxt         = cnt_r + CNT_W'(1);
          fin             = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        // everything moved up, key goes to the bottom
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = j_r;
        mem_req.wr_data = key_r;
        cnt_nxt         = cnt_r + CNT_W'(1);
        fin             = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_SRCH_RD: begin
        if (lo_r < hi1_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mid_sum[ADDR_W:1];
          mid_nxt         = mid_sum[ADDR_W:1];
          state_nxt       = ST_SRCH_CMP;
        end else begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SRCH_CMP: begin
        if (rd_data == key_r) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_pos   = mid_r;
          fin_rank  = cnt_r - {1'b0, mid_r};
          state_nxt = ST_IDLE;
        end else begin
          if (rd_data > key_r) begin
            hi1_nxt = {1'b0, mid_r};
          end else begin
            lo_nxt = {1'b0, mid_r} + CNT_W'(1);
          end
          state_nxt = ST_SRCH_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= fin;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    lo_r  <= lo_nxt;
    hi1_r <= hi1_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin) begin
      out_found_r       <= fin_found;
      out_position_r    <= fin_pos;
      out_rank_r        <= fin_rank;
      out_entry_total_r <= cnt_nxt;
      out_status_r      <= fin_status;
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_position    = out_position_r;
  assign out_rank        = out_rank_r;
  assign out_entry_total = out_entry_total_r;
  assign out_status      = out_status_r;

  // checks
  `STIS_ASSERT(a_cnt_range, cnt_r <= CNT_W'(DEPTH), "entry count above depth")
  `STIS_ASSERT(a_no_rw_clash,
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr),
    "read and write hit the same entry")
  `STIS_ASSERT(a_ins_hole, (state_r == ST_INS) |-> (j_r != '0), "insert shift reached entry zero")
  `STIS_ASSERT(a_hit_rank,
    (out_valid && out_found) |-> ((out_rank + {1'b0, out_position}) == out_entry_total),
    "rank does not match position")

endmodule

### test/sorted_table_insert_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_insert_search_tb
// feeds clear, append, search and unused requests into the sorted table and
// checks every result, field by field, against a scoreboard that keeps its
// own copy of the table; a short directed run over the corners comes first,
// then random runs, some of which fill the table past full, with searches mixed
// in, with random gaps between items and stretches with no gaps at all
// ----------------------------------------------------------------------------
module sorted_table_insert_search_tb import stis_pkg::*; ();

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 70;

  typedef struct packed {
    logic  found;
    addr_t position;
    cnt_t  rank;
    cnt_t  entry_total;
    logic  status;
  } result_t;

  // table copy, expected results and mismatch count
  class table_scoreboard;
    value_t  table_copy[DEPTH];
    int      count;
    int      errors;
    result_t expected_q[$];

    // work out the result of an accepted item and queue it
    function void note_item(logic [1:0] req, value_t key);
      result_t want;
      int j, lo, hi, mid;
      want = '0;
      case (req)
        REQ_CLEAR: count = 0;
        REQ_APPEND: begin
          if (count >= DEPTH) begin
            want.status = 1'b1;
          end else begin
            // larger entries move up, equal ones stay below the new value
            j = count;
            while (j > 0 && key < table_copy[j-1]) begin
              table_copy[j] = table_copy[j-1];
              j--;
            end
            table_copy[j] = key;
            count++;
          end
        end
        REQ_SEARCH: begin
          // binary search with floor midpoints, first hit wins
          lo = 0;
          hi = count - 1;
          while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (table_copy[mid] == key) begin
              want.found    = 1'b1;
              want.position = addr_t'(mid);
              want.rank     = cnt_t'(count - mid);
              break;
            end else if (table_copy[mid] > key) begin
              hi = mid - 1;
            end else begin
              lo = mid + 1;
            end
          end
        end
        default: ;
      endcase
      want.entry_total = cnt_t'(count);
      expected_q.push_back(want);
    endfunction

    // one of the values now held, only called with a non-empty table
    function value_t stored_value();
      return table_copy[$urandom_range(0, count - 1)];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare a result with the oldest expectation
    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no item pending (total %0d)", got.entry_total));
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %b, expected %b", got.found, want.found));
      if (got.position !== want.position)
        report($sformatf("position %0d, expected %0d", got.position, want.position));
      if (got.rank !== want.rank)
        report($sformatf("rank %0d, expected %0d", got.rank, want.rank));
      if (got.entry_total !== want.entry_total)
        report($sformatf("entry_total %0d, expected %0d", got.entry_total,
                         want.entry_total));
      if (got.status !== want.status)
        report($sformatf("status %b, expected %b", got.status, want.status));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_req_type = REQ_CLEAR;
  value_t     in_value = '0;
  logic       out_valid;
  logic       out_found;
  addr_t      out_position;
  cnt_t       out_rank;
  cnt_t       out_entry_total;
  logic       out_status;

  table_scoreboard sb;
  int calm_left = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  sorted_table_insert_search uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_position   (out_position),
    .out_rank       (out_rank),
    .out_entry_total(out_entry_total),
    .out_status     (out_status)
  );

  // small values half the time so equal entries are common, else any value
  function automatic value_t draw_value();
    int v;
    if ($urandom_range(0, 1) == 0) begin
      v = $urandom_range(0, 15);
      v = v - 8;
      return value_t'(v);
    end
    return value_t'($urandom_range(0, 65535));
  endfunction

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(input logic [1:0] req, input value_t key);
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      calm_left = $urandom_range(4, 40);
    end else begin
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_value    <= key;
    do @(posedge clk); while (busy);
    sb.note_item(req, key);
  endtask

  // result monitor
  always @(posedge clk) begin
    result_t seen;
    if (rst_n && out_valid) begin
      seen.found       = out_found;
      seen.position    = out_position;
      seen.rank        = out_rank;
      seen.entry_total = out_entry_total;
      seen.status      = out_status;
      sb.check_result(seen);
    end
  end

  // watchdog on cycles with no item taken and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_table_insert_search_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  sent, target, appends, pick;
    bit  fill, first;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners: empty table, extremes, equal values, unused code
    send_item(REQ_SEARCH, value_t'(0));
    send_item(REQ_UNUSED, value_t'(16'hFFFF));
    send_item(REQ_APPEND, value_t'(0));
    send_item(REQ_APPEND, value_t'(-32768));
    send_item(REQ_APPEND, value_t'(32767));
    send_item(REQ_APPEND, value_t'(-1));
    send_item(REQ_APPEND, value_t'(1));
    send_item(REQ_APPEND, value_t'(0));
    send_item(REQ_APPEND, value_t'(0));
    send_item(REQ_SEARCH, value_t'(0));
    send_item(REQ_SEARCH, value_t'(-32768));
    send_item(REQ_SEARCH, value_t'(32767));
    send_item(REQ_SEARCH, value_t'(5));
    send_item(REQ_SEARCH, value_t'(-32767));
    send_item(REQ_UNUSED, value_t'(16'h5555));
    send_item(REQ_APPEND, value_t'(16'h5555));
    send_item(REQ_APPEND, value_t'(16'hAAAA));
    send_item(REQ_SEARCH, value_t'(16'hAAAA));
    send_item(REQ_SEARCH, value_t'(16'h5555));
    send_item(REQ_CLEAR, value_t'(32767));
    send_item(REQ_SEARCH, value_t'(0));
    send_item(REQ_APPEND, value_t'(-32768));

    // random runs: clear, then appends with searches and unused codes mixed in,
    // and clears in runs that do not fill; the first run and some later ones go past full
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      fill   = first || ($urandom_range(0, 3) == 0);
      first  = 1'b0;
      target = fill ? DEPTH + $urandom_range(1, 4) : $urandom_range(1, 40);
      send_item(REQ_CLEAR, draw_value());
      sent++;
      appends = 0;
      while (appends < target && sent < RANDOM_ITEMS) begin
        pick = $urandom_range(0, fill ? 96 : 99);
        if (pick < 55) begin
          send_item(REQ_APPEND, draw_value());
          appends++;
        end else if (pick < 75 && sb.count > 0) begin
          send_item(REQ_SEARCH, sb.stored_value());
        end else if (pick < 92) begin
          send_item(REQ_SEARCH, draw_value());
        end else if (pick < 97) begin
          send_item(REQ_UNUSED, draw_value());
        end else begin
          send_item(REQ_CLEAR, draw_value());
        end
        sent++;
      end
    end
    start <= 1'b0;

    // drain, then allow stray results to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("sorted_table_insert_search_tb: PASS");
    else
      $display("sorted_table_insert_search_tb: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/stis_pkg.sv
sv/stis_store.sv
sv/sorted_table_insert_search.sv
test/sorted_table_insert_search_tb.sv
